FILE: rtl/core/fvr_pkg.sv
`timescale 1ns / 1ps
// Package for the fade volume ramp: widths, operation codes, the erf S-curve table
// and small level helpers. It depends on nothing else.

package fvr_pkg;

  localparam int LEN_W      = 16;
  localparam int STEP_W     = 13;
  localparam int CSTEP_W    = 14;
  localparam int LEVEL_W    = 24;
  localparam int SUM_W      = 28;
  localparam int DELTA_W    = 26;
  localparam int VOL_W      = 16;
  localparam int DIV_W      = 24;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int ENTRY_W    = 24;
  localparam int PROD_W     = VOL_W + ENTRY_W;

  localparam int CURVE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(CURVE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(CURVE_ENTRIES - 1);

  localparam logic [VOL_W-1:0]   FULL_Q15     = 16'd32768;
  localparam logic [LEVEL_W-1:0] ONE_Q23      = 24'd8388608;
  localparam logic signed [DELTA_W-1:0] DELTA_SAT = 26'sd33554431;
  localparam logic [LEN_W-1:0]   LONG_FADE_MS = 16'd1000;

  // Division of a 16-bit length by the 10 ms tick: (len * 52429) >> 19 is exact.
  localparam logic [16:0] TICK_RECIP = 17'd52429;
  localparam int          TICK_SHIFT = 19;

  localparam int          ERF_TERMS = 40;
  localparam logic [63:0] Q28_ONE   = 64'd268435456;
  localparam logic [63:0] Q28_HALF3 = 64'd402653184;
  localparam logic [63:0] ERF_SCALE = 64'd302896976;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_FADE_IN  = 2'd1,
    OP_FADE_OUT = 2'd2,
    OP_CANCEL   = 2'd3
  } op_t;

  typedef logic [ENTRY_W-1:0] curve_t [CURVE_ENTRIES];

  // S-curve (1 + erf(3x - 1.5)) / 2 in Q1.23, erf from an integer Taylor series in Q28.
  function automatic curve_t build_curve();
    curve_t      tab;
    logic [63:0] zpos;
    logic [63:0] za;
    logic [63:0] z2;
    logic [63:0] t;
    logic [63:0] plus;
    logic [63:0] minus;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] e;
    logic [63:0] c;
    logic        below;
    for (int i = 0; i < CURVE_ENTRIES; i++) begin
      zpos  = 64'(i) * 64'd3 * Q28_ONE / 64'(CURVE_ENTRIES - 1);
      below = zpos < Q28_HALF3;
      za    = below ? Q28_HALF3 - zpos : zpos - Q28_HALF3;
      z2    = (za * za) >> 28;
      t     = za;
      plus  = '0;
      minus = '0;
      for (int n = 0; n < ERF_TERMS; n++) begin
        term = t / 64'(2 * n + 1);
        if (n[0]) begin
          minus = minus + term;
        end else begin
          plus = plus + term;
        end
        t = ((t * z2) >> 28) / 64'(n + 1);
      end
      s = (plus > minus) ? plus - minus : 64'd0;
      e = (s * ERF_SCALE) >> 28;
      if (e > Q28_ONE) begin
        e = Q28_ONE;
      end
      c = below ? Q28_ONE - e : Q28_ONE + e;
      tab[i] = ENTRY_W'((c + 64'd32) >> 6);
    end
    return tab;
  endfunction

  localparam curve_t CURVE_TAB = build_curve();

  function automatic logic [LEVEL_W-1:0] clamp_level(logic signed [SUM_W-1:0] f);
    logic [LEVEL_W-1:0] r;
    if (f < 0) begin
      r = '0;
    end else if (f > $signed({4'b0, ONE_Q23})) begin
      r = ONE_Q23;
    end else begin
      r = f[LEVEL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [VOL_W-1:0] round_volume(logic [LEVEL_W-1:0] lvl);
    return VOL_W'(({1'b0, lvl} + 25'd128) >> 8);
  endfunction

endpackage

FILE: rtl/core/fade_volume_ramp.sv
`timescale 1ns / 1ps
// Fade volume ramp top level: command decode, fade state, shared restoring divider,
// curve lookup and multiply, and the output register. It depends on fvr_pkg.
//
// An item on the input channel (in_valid, in_stall) is a tick or a fade command.
// Every item gives exactly one result on the output channel (out_valid, out_stall).
// The master volume is written on the configuration channel (cfg_valid, cfg_ready),
// which is always ready and must only be written while no item is in flight.
// One item is taken at a time; in_stall is high from acceptance until the result is
// loaded into the output register. The cost is set by the one restoring divider.
// An idle tick, a linear tick or a cancel goes from decode to the result; a start
// command that reverses a fade or has zero steps adds setup, and one that divides the
// span to its target level by the step count adds setup and the divider; a curve tick
// adds lookup, multiply and finish, and the divider before them when it divides the
// step position, that is when it has a nonzero step count.
// The result register sits apart from the datapath, so the next item is accepted
// while a result still waits; a stalled receiver holds the block only when a second
// result is ready, and then the block waits before loading it.
// Synchronous reset clears all fade state, the master volume and the output valid.

module fade_volume_ramp
  import fvr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       operation,
  input  logic [LEN_W-1:0] fade_length_ms,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VOL_W-1:0] output_volume,
  output logic             volume_update,
  output logic             request_pause,
  output logic             fade_active,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [VOL_W-1:0] master_volume
);

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_DECODE    = 8'b0000_0010,
    ST_SETUP     = 8'b0000_0100,
    ST_DIV       = 8'b0000_1000,
    ST_LOOKUP    = 8'b0001_0000,
    ST_MUL       = 8'b0010_0000,
    ST_CURVE_FIN = 8'b0100_0000,
    ST_DONE      = 8'b1000_0000
  } state_t;

  state_t state;
  op_t    op_r;
  logic [LEN_W-1:0] len_r;
  logic [VOL_W-1:0] master_level;

  logic signed [CSTEP_W-1:0] current_step;
  logic [STEP_W-1:0]         total_steps;
  logic signed [DELTA_W-1:0] step_delta;
  logic [LEVEL_W-1:0]        fade_level;
  logic fade_level_valid;
  logic reversing;
  logic fading_out;
  logic curve_mode;
  logic ticking;

  logic [DIV_W-1:0]     div_quo;
  logic [STEP_W-1:0]    div_rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic div_for_index;
  logic delta_neg;

  logic [IDX_W-1:0]   idx_r;
  logic [ENTRY_W-1:0] entry_r;
  logic [PROD_W-1:0]  prod_r;
  logic [VOL_W-1:0]   res_volume;
  logic res_update;
  logic res_pause;

  logic [VOL_W-1:0]   master15;
  logic [LEVEL_W-1:0] m23;
  logic [32:0]        len_prod;
  logic [STEP_W-1:0]  len_steps;
  logic len_long;
  logic len_nz;
  logic new_rev;
  logic in_fade;
  logic [20:0] pos_x255;
  logic signed [SUM_W-1:0] lin_base;
  logic signed [SUM_W-1:0] lin_sum;
  logic [LEVEL_W-1:0] lin_level;
  logic [LEVEL_W-1:0] curve_p;
  logic signed [SUM_W-1:0] curve_f;
  logic [LEVEL_W-1:0] curve_level;
  logic [LEVEL_W-1:0] base_in;
  logic [LEVEL_W-1:0] diff_in;
  logic [LEVEL_W-1:0] lvl_out;
  logic [LEVEL_W-1:0] setup_level;
  logic [LEVEL_W-1:0] setup_num;
  logic setup_div;
  logic [STEP_W:0]  rem_shift;
  logic             div_bit;
  logic [STEP_W:0]  rem_new;
  logic [DIV_W-1:0] quo_new;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    master15  = (master_level > FULL_Q15) ? FULL_Q15 : master_level;
    m23       = {master15, 8'd0};
    len_prod  = 33'(len_r) * 33'(TICK_RECIP);
    len_steps = len_prod[STEP_W+TICK_SHIFT-1:TICK_SHIFT];
    len_long  = (len_r >= LONG_FADE_MS);
    len_nz    = (len_r != '0);
    new_rev   = !reversing && (current_step > 0) && len_nz;
    in_fade   = reversing ? (current_step >= 0)
                          : (current_step <= $signed({1'b0, total_steps}));
    pos_x255  = {current_step[STEP_W-1:0], 8'd0} - 21'(current_step[STEP_W-1:0]);

    lin_base  = fade_level_valid ? $signed({4'b0, fade_level}) : -$signed({4'b0, ONE_Q23});
    lin_sum   = lin_base + {{(SUM_W-DELTA_W){step_delta[DELTA_W-1]}}, step_delta};
    lin_level = clamp_level(lin_sum);

    curve_p   = LEVEL_W'((prod_r + 40'd16384) >> 15);
    curve_f   = (reversing ^ fading_out) ? $signed({4'b0, m23}) - $signed({4'b0, curve_p})
                                         : $signed({4'b0, curve_p});
    curve_level = clamp_level(curve_f);

    base_in   = (fade_level_valid && fade_level != '0) ? fade_level : '0;
    diff_in   = (base_in > m23) ? base_in - m23 : m23 - base_in;
    lvl_out   = (!fade_level_valid || fade_level == '0) ? m23 : fade_level;
    setup_level = (op_r == OP_FADE_OUT) ? lvl_out : base_in;
    setup_num   = (op_r == OP_FADE_OUT) ? lvl_out : diff_in;
    setup_div   = (op_r == OP_FADE_OUT) ? !reversing : (!reversing && len_nz);

    rem_shift = {div_rem, div_quo[DIV_W-1]};
    div_bit   = (rem_shift >= {1'b0, total_steps});
    rem_new   = div_bit ? rem_shift - {1'b0, total_steps} : rem_shift;
    quo_new   = {div_quo[DIV_W-2:0], div_bit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      master_level     <= '0;
      current_step     <= '0;
      total_steps      <= '0;
      step_delta       <= '0;
      fade_level       <= '0;
      fade_level_valid <= 1'b0;
      reversing        <= 1'b0;
      fading_out       <= 1'b0;
      curve_mode       <= 1'b0;
      ticking          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        master_level <= master_volume;
      end
      if (state == ST_DONE) begin
        if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_r  <= op_t'(operation);
            len_r <= fade_length_ms;
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          unique case (op_r)
            OP_TICK: begin
              res_update <= ticking;
              if (!ticking) begin
                res_volume <= '0;
                res_pause  <= 1'b0;
                state      <= ST_DONE;
              end else if (!in_fade) begin
                res_volume       <= master15;
                res_pause        <= step_delta[DELTA_W-1];
                fade_level_valid <= 1'b0;
                fade_level       <= '0;
                current_step     <= '0;
                reversing        <= 1'b0;
                ticking          <= 1'b0;
                state            <= ST_DONE;
              end else begin
                res_pause <= 1'b0;
                if (reversing) begin
                  current_step <= current_step - 14'sd1;
                end else begin
                  current_step <= current_step + 14'sd1;
                end
                if (curve_mode) begin
                  if (total_steps != '0) begin
                    div_quo       <= DIV_W'(pos_x255);
                    div_rem       <= '0;
                    div_cnt       <= DIV_CNT_W'(DIV_W - 1);
                    div_for_index <= 1'b1;
                    state         <= ST_DIV;
                  end else begin
                    idx_r <= IDX_MAX;
                    state <= ST_LOOKUP;
                  end
                end else begin
                  fade_level       <= lin_level;
                  fade_level_valid <= 1'b1;
                  res_volume <= (total_steps != '0) ? round_volume(lin_level) : master15;
                  state      <= ST_DONE;
                end
              end
            end
            OP_FADE_IN, OP_FADE_OUT: begin
              res_volume <= '0;
              res_update <= 1'b0;
              res_pause  <= 1'b0;
              ticking    <= 1'b1;
              reversing  <= new_rev;
              curve_mode <= len_long;
              fading_out <= (op_r == OP_FADE_OUT);
              if (!new_rev) begin
                total_steps  <= len_steps;
                current_step <= '0;
                step_delta   <= '0;
              end
              state <= ST_SETUP;
            end
            OP_CANCEL: begin
              res_volume       <= '0;
              res_update       <= 1'b0;
              res_pause        <= 1'b0;
              ticking          <= 1'b0;
              reversing        <= 1'b0;
              curve_mode       <= 1'b0;
              fading_out       <= 1'b0;
              total_steps      <= '0;
              current_step     <= '0;
              step_delta       <= '0;
              fade_level_valid <= 1'b0;
              fade_level       <= '0;
              state            <= ST_DONE;
            end
          endcase
        end
        ST_SETUP: begin
          if (setup_div) begin
            fade_level       <= setup_level;
            fade_level_valid <= 1'b1;
            delta_neg        <= (op_r == OP_FADE_OUT);
            if (total_steps == '0) begin
              if (setup_num == '0) begin
                step_delta <= '0;
              end else if (op_r == OP_FADE_OUT) begin
                step_delta <= -DELTA_SAT;
              end else begin
                step_delta <= DELTA_SAT;
              end
              state <= ST_DONE;
            end else begin
              div_quo       <= setup_num;
              div_rem       <= '0;
              div_cnt       <= DIV_CNT_W'(DIV_W - 1);
              div_for_index <= 1'b0;
              state         <= ST_DIV;
            end
          end else begin
            step_delta <= -step_delta;
            state      <= ST_DONE;
          end
        end
        ST_DIV: begin
          div_quo <= quo_new;
          div_rem <= rem_new[STEP_W-1:0];
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            if (div_for_index) begin
              idx_r <= (quo_new < DIV_W'(IDX_MAX)) ? quo_new[IDX_W-1:0] : IDX_MAX;
              state <= ST_LOOKUP;
            end else begin
              step_delta <= delta_neg ? -$signed({2'b0, quo_new}) : $signed({2'b0, quo_new});
              state      <= ST_DONE;
            end
          end
        end
        ST_LOOKUP: begin
          entry_r <= CURVE_TAB[idx_r];
          state   <= ST_MUL;
        end
        ST_MUL: begin
          prod_r <= PROD_W'(master15) * PROD_W'(entry_r);
          state  <= ST_CURVE_FIN;
        end
        ST_CURVE_FIN: begin
          fade_level       <= curve_level;
          fade_level_valid <= 1'b1;
          res_volume <= (total_steps != '0) ? round_volume(curve_level) : master15;
          state      <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            output_volume <= res_volume;
            volume_update <= res_update;
            request_pause <= res_pause;
            fade_active   <= ticking;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    fade_level <= ONE_Q23)
    else $error("Fade level is above full scale.");

  a_level_cleared: assert property (@(posedge clk) disable iff (rst)
    !fade_level_valid |-> fade_level == '0)
    else $error("An absent fade level is not zero.");

  a_quiet_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !volume_update |-> output_volume == '0 && !request_pause)
    else $error("A result without an update carries a volume or a pause.");

  a_pause_ends_fade: assert property (@(posedge clk) disable iff (rst)
    out_valid && request_pause |-> volume_update && !fade_active)
    else $error("A pause request does not end the fade.");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> total_steps != '0)
    else $error("The divider runs with a zero step count.");

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == ST_DECODE)
    else $error("An accepted item is not decoded.");

endmodule
